FILE: rtl/gwct_pkg.sv
// ----------------------------------------------------------------------------
// gwct_pkg
// Shared types, widths and the Gaussian weight table for the color transfer.
// ----------------------------------------------------------------------------
package gwct_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int NUM_CH      = 3;
    localparam int SLOTS       = MAX_REGIONS * NUM_CH;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int REG_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

    localparam int CFG_W       = 5;
    localparam int PIX_W       = 8;
    localparam int MEAN_W      = 16;
    localparam int WGT_W       = 16;
    localparam int D_W         = 17;
    localparam int M_W         = 9;
    localparam int V_W         = 34;
    localparam int PROD_W      = V_W + WGT_W + 1;
    localparam int NUM_W       = 50 + CNT_W;
    localparam int WSUM_W      = WGT_W + CNT_W;
    localparam int REM_W       = NUM_W - 1;
    localparam int FRAC_SH     = 20;
    localparam int Q_W         = 8;
    localparam int DV_W        = WSUM_W + FRAC_SH + Q_W;
    localparam int STEP_W      = 4;

    localparam int ROM_SIZE    = 257;
    localparam logic [63:0] EXP_STEP_Q32 = 64'd4284024710;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_OUTPUT
    } t_state;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_PIXEL = 1'b1
    } t_action;

    typedef struct packed {
        logic [MEAN_W-1:0] src_mean;
        logic [MEAN_W-1:0] ref_mean;
        logic [MEAN_W-1:0] gain;
    } t_tab_entry;

    typedef logic [WGT_W-1:0] t_weight_rom [ROM_SIZE];

    // exp(-m*m/392) in Q0.16, stepped once per unit of m*m
    function automatic t_weight_rom build_weight_rom();
        t_weight_rom rom;
        logic [63:0] acc;
        logic [63:0] scaled;
        int unsigned q;
        int unsigned target;
        logic        zero;
        acc  = 64'd1 << 32;
        q    = 0;
        zero = 1'b0;
        for (int m = 0; m < ROM_SIZE; m++) begin
            target = m * m;
            while (!zero && q < target) begin
                acc = (acc * EXP_STEP_Q32) >> 32;
                q   = q + 1;
            end
            scaled = (acc * 64'd65535 + (64'd1 << 31)) >> 32;
            rom[m] = scaled[WGT_W-1:0];
            if (scaled == 64'd0) begin
                zero = 1'b1;
            end
        end
        return rom;
    endfunction

    localparam t_weight_rom WEIGHT_ROM = build_weight_rom();

endpackage

FILE: rtl/gaussian_weighted_color_transfer.sv
// ----------------------------------------------------------------------------
// gaussian_weighted_color_transfer
// Region-blended Reinhard color transfer with Gaussian weights per region.
// ----------------------------------------------------------------------------
// A load transaction (action 0) writes one region/channel table entry. A pixel
// transaction (action 1) walks N regions, N being min(region_count, 16): the
// table memory is read one region/channel entry per cycle through a two-stage
// multiply/accumulate pipeline, then one shared restoring divider works on
// each of the three channels in turn.
// The input stalls while a pixel is in flight; the result sits in an output
// register, so the next transaction is taken while it waits to be consumed.
module gaussian_weighted_color_transfer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gwct_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_action,
    input  logic [3:0]                     i_region_index,
    input  logic [1:0]                     i_channel,
    input  logic                           i_region_used,
    input  logic [gwct_pkg::MEAN_W-1:0]    i_src_mean,
    input  logic [gwct_pkg::MEAN_W-1:0]    i_ref_mean,
    input  logic [gwct_pkg::MEAN_W-1:0]    i_gain,
    input  logic [gwct_pkg::PIX_W-1:0]     i_pixel_ch0,
    input  logic [gwct_pkg::PIX_W-1:0]     i_pixel_ch1,
    input  logic [gwct_pkg::PIX_W-1:0]     i_pixel_ch2,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [gwct_pkg::PIX_W-1:0]     o_out_ch0,
    output logic [gwct_pkg::PIX_W-1:0]     o_out_ch1,
    output logic [gwct_pkg::PIX_W-1:0]     o_out_ch2,
    output logic                           o_covered
);
    import gwct_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [CFG_W-1:0]      r_region_count;
    logic                  r_used [MAX_REGIONS];
    t_tab_entry            r_tab_mem [SLOTS];

    logic [PIX_W-1:0]      r_pix [NUM_CH];
    logic [CNT_W-1:0]      r_reg_cnt;
    logic [1:0]            r_ch;
    logic [SLOT_W-1:0]     r_slot;

    t_tab_entry            r_rd_data;
    logic                  r_s1_valid;
    logic [1:0]            r_s1_ch;
    logic [WGT_W-1:0]      r_w;
    logic signed [V_W-1:0] r_v;
    logic                  r_s2_valid;
    logic [1:0]            r_s2_ch;

    logic signed [NUM_W-1:0] r_num [NUM_CH];
    logic [WSUM_W-1:0]       r_wsum [NUM_CH];

    logic [1:0]            r_div_ch;
    logic [STEP_W-1:0]     r_step;
    logic [REM_W-1:0]      r_rem;
    logic [DV_W-1:0]       r_dv;
    logic [Q_W-1:0]        r_q;
    logic                  r_sat;
    logic                  r_pos;
    logic [PIX_W-1:0]      r_res [NUM_CH];

    logic                  r_out_valid;
    logic [PIX_W-1:0]      r_out_ch [NUM_CH];
    logic                  r_covered;

    logic                  in_accept;
    logic                  load_we;
    logic [SLOT_W-1:0]     load_slot;
    logic [CNT_W-1:0]      walk;
    logic                  walk_more;
    logic                  issue;
    logic                  div_load;
    logic                  div_step;
    logic                  out_load;
    logic                  out_free;

    logic [PIX_W-1:0]      s1_pix;
    logic signed [D_W-1:0] s1_d;
    logic [D_W-1:0]        s1_mag;
    logic [D_W:0]          s1_round;
    logic [M_W-1:0]        s1_m;
    logic signed [V_W-1:0] s1_v;
    logic signed [PROD_W-1:0] s2_prod;

    logic signed [NUM_W-1:0] div_num;
    logic [WSUM_W-1:0]       div_wsum;
    logic                    rem_ge;
    logic [Q_W-1:0]          q_next;
    logic [PIX_W-1:0]        ch_result;
    logic                    all_nonzero;

    // ------------------------------------------------------------------ control
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        if (32'(r_region_count) > 32'(MAX_REGIONS)) begin
            walk = CNT_W'(MAX_REGIONS);
        end else begin
            walk = CNT_W'(r_region_count);
        end
    end

    assign walk_more = r_reg_cnt < walk;
    assign load_slot = SLOT_W'(32'(i_region_index) * NUM_CH + 32'(i_channel));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && i_action == ACT_PIXEL) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!walk_more) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_s1_valid && !r_s2_valid) begin
                    n_state = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD: begin
                n_state = ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
                if (r_step == '0) begin
                    n_state = (r_div_ch == 2'(NUM_CH - 1)) ? ST_OUTPUT : ST_DIV_LOAD;
                end
            end
            ST_OUTPUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        load_we    = 1'b0;
        issue      = 1'b0;
        div_load   = 1'b0;
        div_step   = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = !i_rst_n;
                load_we    = in_accept && i_action == ACT_LOAD && i_channel != 2'd3
                             && 32'(i_region_index) < 32'(MAX_REGIONS);
            end
            ST_WALK: begin
                issue = walk_more && r_used[r_reg_cnt[REG_W-1:0]];
            end
            ST_DRAIN: begin
                issue = 1'b0;
            end
            ST_DIV_LOAD: begin
                div_load = 1'b1;
            end
            ST_DIV_STEP: begin
                div_step = 1'b1;
            end
            ST_OUTPUT: begin
                out_load = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_region_count <= '0;
            r_s1_valid     <= 1'b0;
            r_s2_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int r = 0; r < MAX_REGIONS; r++) begin
                r_used[r] <= 1'b0;
            end
        end else begin
            r_state    <= n_state;
            r_s1_valid <= issue;
            r_s2_valid <= r_s1_valid;
            if (i_cfg_we) begin
                r_region_count <= i_cfg_wdata;
            end
            if (load_we) begin
                r_used[REG_W'(i_region_index)] <= i_region_used;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------- table memory
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_tab_mem[load_slot] <= '{src_mean: i_src_mean,
                                     ref_mean: i_ref_mean,
                                     gain:     i_gain};
        end
        if (issue) begin
            r_rd_data <= r_tab_mem[r_slot];
        end
    end

    // ------------------------------------------------------------- walk counters
    always_ff @(posedge i_clk) begin
        if (in_accept && i_action == ACT_PIXEL) begin
            r_pix[0]  <= i_pixel_ch0;
            r_pix[1]  <= i_pixel_ch1;
            r_pix[2]  <= i_pixel_ch2;
            r_reg_cnt <= '0;
            r_ch      <= '0;
            r_slot    <= '0;
        end else if (r_state == ST_WALK && walk_more) begin
            r_slot <= r_slot + SLOT_W'(1);
            if (r_ch == 2'(NUM_CH - 1)) begin
                r_ch      <= '0;
                r_reg_cnt <= r_reg_cnt + CNT_W'(1);
            end else begin
                r_ch <= r_ch + 2'd1;
            end
        end
        r_s1_ch <= r_ch;
    end

    // --------------------------------------------------- weight and correction
    always_comb begin
        case (r_s1_ch)
            2'd0:    s1_pix = r_pix[0];
            2'd1:    s1_pix = r_pix[1];
            2'd2:    s1_pix = r_pix[2];
            default: s1_pix = r_pix[0];
        endcase
        s1_d     = $signed({1'b0, s1_pix, 8'b0}) - $signed({1'b0, r_rd_data.src_mean});
        s1_mag   = s1_d[D_W-1] ? D_W'(-s1_d) : D_W'(s1_d);
        s1_round = {1'b0, s1_mag} + (D_W+1)'(128);
        s1_m     = s1_round[M_W+7:8];
        s1_v     = V_W'($signed({1'b0, r_rd_data.gain}) * s1_d)
                   + $signed({{(V_W-MEAN_W-12){1'b0}}, r_rd_data.ref_mean, 12'b0});
    end

    always_ff @(posedge i_clk) begin
        r_w     <= WEIGHT_ROM[s1_m];
        r_v     <= s1_v;
        r_s2_ch <= r_s1_ch;
    end

    assign s2_prod = PROD_W'($signed({1'b0, r_w}) * r_v);

    always_ff @(posedge i_clk) begin
        if (in_accept && i_action == ACT_PIXEL) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_num[c]  <= '0;
                r_wsum[c] <= '0;
            end
        end else if (r_s2_valid) begin
            for (int c = 0; c < NUM_CH; c++) begin
                if (r_s2_ch == 2'(c)) begin
                    r_num[c]  <= r_num[c] + NUM_W'(s2_prod);
                    r_wsum[c] <= r_wsum[c] + WSUM_W'(r_w);
                end
            end
        end
    end

    // ---------------------------------------------------------- shared divider
    always_comb begin
        case (r_div_ch)
            2'd0:    begin div_num = r_num[0]; div_wsum = r_wsum[0]; end
            2'd1:    begin div_num = r_num[1]; div_wsum = r_wsum[1]; end
            2'd2:    begin div_num = r_num[2]; div_wsum = r_wsum[2]; end
            default: begin div_num = r_num[0]; div_wsum = r_wsum[0]; end
        endcase
        rem_ge = r_rem >= REM_W'(r_dv);
        q_next = r_q;
        if (r_step < STEP_W'(Q_W) && rem_ge) begin
            q_next = r_q | (Q_W'(1) << r_step[2:0]);
        end
        if (!r_pos) begin
            ch_result = '0;
        end else if (r_sat) begin
            ch_result = '1;
        end else begin
            ch_result = q_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DRAIN) begin
            r_div_ch <= '0;
        end else if (div_step && r_step == '0) begin
            r_div_ch <= r_div_ch + 2'd1;
        end
        if (div_load) begin
            r_pos  <= !div_num[NUM_W-1] && div_num != '0;
            r_rem  <= div_num[NUM_W-1] ? '0 : div_num[REM_W-1:0];
            r_dv   <= {div_wsum, {(FRAC_SH + Q_W){1'b0}}};
            r_step <= STEP_W'(Q_W);
            r_q    <= '0;
            r_sat  <= 1'b0;
        end else if (div_step) begin
            r_dv   <= r_dv >> 1;
            r_step <= r_step - STEP_W'(1);
            if (r_step == STEP_W'(Q_W)) begin
                r_sat <= rem_ge;
            end else begin
                r_q <= q_next;
                if (rem_ge) begin
                    r_rem <= r_rem - REM_W'(r_dv);
                end
            end
            if (r_step == '0) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    if (r_div_ch == 2'(c)) begin
                        r_res[c] <= ch_result;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------- output register
    assign all_nonzero = (r_wsum[0] != '0) && (r_wsum[1] != '0) && (r_wsum[2] != '0);

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_out_ch[c] <= all_nonzero ? r_res[c] : '0;
            end
            r_covered <= all_nonzero;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_ch0   = r_out_ch[0];
    assign o_out_ch1   = r_out_ch[1];
    assign o_out_ch2   = r_out_ch[2];
    assign o_covered   = r_covered;

endmodule
